// ===== hw/rtl/bb3_pkg.sv =====
package bb3_pkg;

	// frame limits
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int COL_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_W      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

	// field widths
	localparam int CFG_W   = 11;
	localparam int CH_W    = 8;
	localparam int PIX_W   = 3 * CH_W;
	localparam int COORD_W = 10;

	// arithmetic widths: sum of nine channels, count up to nine,
	// numerator 2*sum+count, reciprocal of 2*count
	localparam int SUM_W       = 12;
	localparam int CNT_W       = 4;
	localparam int NUM_W       = 13;
	localparam int RECIP_W     = 18;
	localparam int RECIP_SHIFT = 18;
	localparam int PROD_W      = NUM_W + RECIP_W;

	// register indexes
	localparam logic [0:0] REG_WIDTH  = 1'b0;
	localparam logic [0:0] REG_HEIGHT = 1'b1;

	typedef logic [PIX_W-1:0] pix_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_LOAD = 4'b0010,
		ST_SUM  = 4'b0100,
		ST_DIV  = 4'b1000
	} state_t;

	// ceil(2^RECIP_SHIFT / (2*cnt)) for the possible neighbour counts
	function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
		logic [RECIP_W-1:0] m;
		case (cnt)
			4'd1:    m = 18'd131072;
			4'd2:    m = 18'd65536;
			4'd3:    m = 18'd43691;
			4'd4:    m = 18'd32768;
			4'd6:    m = 18'd21846;
			4'd9:    m = 18'd14564;
			default: m = 18'd131072;
		endcase
		return m;
	endfunction

endpackage

// ===== hw/rtl/bb3_ram.sv =====
module bb3_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/box_blur_three_by_three_core.sv =====
// 3x3 box blur over a streamed RGB frame.
// Input channel: in_valid / in_stall with in_red, in_green, in_blue, one pixel
// per item in raster order. Output channel: out_valid / out_stall with the
// blurred pixel's coordinates, its rounded mean colors and run_last, which
// marks the last result caused by one input item (zero to four results).
// Configuration: cfg_write with cfg_index and cfg_data sets image_width or
// image_height; any write restarts the frame at pixel (0,0).
// Each input item passes through a line store read, then window update and
// line store write, plus a sum step and a divide step by reciprocal multiply
// into the output register for each result it causes. A single read-modify-
// write of the two line store banks is done per item. The block takes no new
// item until it is through with the last one: in_stall is high outside idle.
// Reset clears the window to zero, the position to (0,0) and width and height
// to 1024; the line store is not cleared. While the receiver stalls, the output
// register holds its result and the block waits before loading the next.
module box_blur_three_by_three_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [0:0]                      cfg_index,
	input  logic [bb3_pkg::CFG_W-1:0]       cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [bb3_pkg::CH_W-1:0]        in_red,
	input  logic [bb3_pkg::CH_W-1:0]        in_green,
	input  logic [bb3_pkg::CH_W-1:0]        in_blue,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [bb3_pkg::COORD_W-1:0]     out_row,
	output logic [bb3_pkg::COORD_W-1:0]     out_col,
	output logic [bb3_pkg::CH_W-1:0]        out_red,
	output logic [bb3_pkg::CH_W-1:0]        out_green,
	output logic [bb3_pkg::CH_W-1:0]        out_blue,
	output logic                            run_last
);

	localparam int CW = bb3_pkg::CFG_W;
	localparam int HW = bb3_pkg::CH_W;

	bb3_pkg::state_t state_q;

	logic [CW-1:0] width_q, height_q, eff_w, eff_h;
	logic [bb3_pkg::COL_W-1:0] col_q, c_cur, c_q;
	logic [bb3_pkg::ROW_W-1:0] row_q, r_cur, r_q;
	logic restart, in_acc, out_load;
	bb3_pkg::pix_t pix_q;
	bb3_pkg::pix_t win_q [9];
	bb3_pkg::pix_t old_rdata, new_rdata;
	logic ram_we;
	logic has_r1_q, has_r2_q, has_c1_q, has_c2_q;
	logic ra_is2_q, cb_is2_q;
	logic more_c, more_r;

	logic [bb3_pkg::SUM_W-1:0] sum_r, sum_g, sum_b;
	logic [bb3_pkg::CNT_W-1:0] cnt;
	logic [2:0] a_ok, b_ok;
	logic [bb3_pkg::SUM_W-1:0] sum_r_s1, sum_g_s1, sum_b_s1;
	logic [bb3_pkg::CNT_W-1:0] cnt_s1;
	logic [bb3_pkg::COORD_W-1:0] row_s1, col_s1;
	logic last_s1;

	logic [bb3_pkg::RECIP_W-1:0] m_val;
	logic [bb3_pkg::NUM_W-1:0] num_r, num_g, num_b;
	logic [bb3_pkg::PROD_W-1:0] prod_r, prod_g, prod_b;

	logic out_valid_q;

	// effective frame size
	always_comb begin
		eff_w = width_q;
		if (width_q == '0) eff_w = CW'(1);
		else if (width_q > CW'(bb3_pkg::MAX_WIDTH)) eff_w = CW'(bb3_pkg::MAX_WIDTH);
		eff_h = height_q;
		if (height_q == '0) eff_h = CW'(1);
		else if (height_q > CW'(bb3_pkg::MAX_HEIGHT)) eff_h = CW'(bb3_pkg::MAX_HEIGHT);
	end

	// position of the incoming pixel
	assign restart = (CW'(col_q) >= eff_w) || (CW'(row_q) >= eff_h);
	assign c_cur   = restart ? '0 : col_q;
	assign r_cur   = restart ? '0 : row_q;
	assign in_stall = (state_q != bb3_pkg::ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_load = (state_q == bb3_pkg::ST_DIV) && (!out_valid_q || !out_stall);
	assign ram_we   = (state_q == bb3_pkg::ST_LOAD);

	// line store banks: older row and newer row per column
	bb3_ram #(.WIDTH(bb3_pkg::PIX_W), .DEPTH(bb3_pkg::MAX_WIDTH)) u_old_bank (
		.clk   (clk),
		.we    (ram_we),
		.waddr (c_q),
		.wdata (new_rdata),
		.raddr (c_cur),
		.rdata (old_rdata)
	);

	bb3_ram #(.WIDTH(bb3_pkg::PIX_W), .DEPTH(bb3_pkg::MAX_WIDTH)) u_new_bank (
		.clk   (clk),
		.we    (ram_we),
		.waddr (c_q),
		.wdata (pix_q),
		.raddr (c_cur),
		.rdata (new_rdata)
	);

	// in-image cells of the window around the current center
	always_comb begin
		a_ok[0] = !ra_is2_q && (r_q >= 2);
		a_ok[1] = (r_q >= 1);
		a_ok[2] = 1'b1;
		b_ok[0] = !cb_is2_q && (c_q >= 2);
		b_ok[1] = (c_q >= 1);
		b_ok[2] = 1'b1;
		sum_r = '0;
		sum_g = '0;
		sum_b = '0;
		cnt   = '0;
		for (int a = 0; a < 3; a++) begin
			for (int b = 0; b < 3; b++) begin
				if (a_ok[a] && b_ok[b]) begin
					sum_r = sum_r + bb3_pkg::SUM_W'(win_q[a*3+b][3*HW-1:2*HW]);
					sum_g = sum_g + bb3_pkg::SUM_W'(win_q[a*3+b][2*HW-1:HW]);
					sum_b = sum_b + bb3_pkg::SUM_W'(win_q[a*3+b][HW-1:0]);
					cnt   = cnt + bb3_pkg::CNT_W'(1);
				end
			end
		end
	end

	assign more_c = !cb_is2_q && has_c2_q;
	assign more_r = !ra_is2_q && has_r2_q;

	// rounded mean: (2*sum+cnt) * ceil(2^k/(2*cnt)) >> k
	assign m_val  = bb3_pkg::recip(cnt_s1);
	assign num_r  = {sum_r_s1, 1'b0} + bb3_pkg::NUM_W'(cnt_s1);
	assign num_g  = {sum_g_s1, 1'b0} + bb3_pkg::NUM_W'(cnt_s1);
	assign num_b  = {sum_b_s1, 1'b0} + bb3_pkg::NUM_W'(cnt_s1);
	assign prod_r = bb3_pkg::PROD_W'(num_r) * bb3_pkg::PROD_W'(m_val);
	assign prod_g = bb3_pkg::PROD_W'(num_g) * bb3_pkg::PROD_W'(m_val);
	assign prod_b = bb3_pkg::PROD_W'(num_b) * bb3_pkg::PROD_W'(m_val);

	// control: state, configuration, position, selection of centers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bb3_pkg::ST_IDLE;
			width_q     <= CW'(bb3_pkg::MAX_WIDTH);
			height_q    <= CW'(bb3_pkg::MAX_HEIGHT);
			col_q       <= '0;
			row_q       <= '0;
			out_valid_q <= 1'b0;
			ra_is2_q    <= 1'b0;
			cb_is2_q    <= 1'b0;
			for (int k = 0; k < 9; k++) win_q[k] <= '0;
		end else begin
			if (cfg_write) begin
				if (cfg_index == bb3_pkg::REG_WIDTH) width_q <= cfg_data;
				else height_q <= cfg_data;
				col_q <= '0;
				row_q <= '0;
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			case (state_q)
				bb3_pkg::ST_IDLE: begin
					if (in_acc) begin
						state_q <= bb3_pkg::ST_LOAD;
						if (CW'(c_cur) + CW'(1) >= eff_w) begin
							col_q <= '0;
							if (CW'(r_cur) + CW'(1) >= eff_h) row_q <= '0;
							else row_q <= r_cur + 1'b1;
						end else begin
							col_q <= c_cur + 1'b1;
							row_q <= r_cur;
						end
					end
				end
				bb3_pkg::ST_LOAD: begin
					for (int k = 0; k < 3; k++) begin
						win_q[k*3]   <= win_q[k*3+1];
						win_q[k*3+1] <= win_q[k*3+2];
					end
					win_q[2] <= old_rdata;
					win_q[5] <= new_rdata;
					win_q[8] <= pix_q;
					ra_is2_q <= !has_r1_q;
					cb_is2_q <= !has_c1_q;
					if ((has_r1_q || has_r2_q) && (has_c1_q || has_c2_q))
						state_q <= bb3_pkg::ST_SUM;
					else
						state_q <= bb3_pkg::ST_IDLE;
				end
				bb3_pkg::ST_SUM: begin
					state_q <= bb3_pkg::ST_DIV;
					if (more_c) begin
						cb_is2_q <= 1'b1;
					end else if (more_r) begin
						ra_is2_q <= 1'b1;
						cb_is2_q <= !has_c1_q;
					end
				end
				bb3_pkg::ST_DIV: begin
					if (out_load) state_q <= last_s1 ? bb3_pkg::ST_IDLE : bb3_pkg::ST_SUM;
				end
				default: state_q <= bb3_pkg::ST_IDLE;
			endcase
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_q    <= {in_red, in_green, in_blue};
			c_q      <= c_cur;
			r_q      <= r_cur;
			has_r1_q <= (r_cur != '0);
			has_r2_q <= (CW'(r_cur) == eff_h - CW'(1));
			has_c1_q <= (c_cur != '0);
			has_c2_q <= (CW'(c_cur) == eff_w - CW'(1));
		end
	end

	// sum stage
	always_ff @(posedge clk) begin
		if (state_q == bb3_pkg::ST_SUM) begin
			sum_r_s1 <= sum_r;
			sum_g_s1 <= sum_g;
			sum_b_s1 <= sum_b;
			cnt_s1   <= cnt;
			row_s1   <= bb3_pkg::COORD_W'(ra_is2_q ? r_q : r_q - 1'b1);
			col_s1   <= bb3_pkg::COORD_W'(cb_is2_q ? c_q : c_q - 1'b1);
			last_s1  <= !(more_c || more_r);
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_row   <= row_s1;
			out_col   <= col_s1;
			out_red   <= prod_r[bb3_pkg::RECIP_SHIFT +: HW];
			out_green <= prod_g[bb3_pkg::RECIP_SHIFT +: HW];
			out_blue  <= prod_b[bb3_pkg::RECIP_SHIFT +: HW];
			run_last  <= last_s1;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTH
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register not one-hot");

	a_wr_matches_rd: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (c_q == $past(c_cur)))
		else $error("line store written at a column other than the one read");

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == bb3_pkg::ST_LOAD))
		else $error("accepted item not followed by line store update");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall && state_q == bb3_pkg::ST_DIV) |=>
		(state_q == bb3_pkg::ST_DIV))
		else $error("result dropped while output stalled");
`endif

endmodule

// ===== tb/sv/box_blur_three_by_three_core_tb.sv =====
`timescale 1ns / 100ps

module box_blur_three_by_three_core_tb;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 16;

	typedef struct {
		logic [bb3_pkg::COORD_W-1:0] row;
		logic [bb3_pkg::COORD_W-1:0] col;
		logic [bb3_pkg::CH_W-1:0]    red;
		logic [bb3_pkg::CH_W-1:0]    green;
		logic [bb3_pkg::CH_W-1:0]    blue;
		logic                        last;
	} blur_px_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_write = 1'b0;
	logic [0:0]                  cfg_index = bb3_pkg::REG_WIDTH;
	logic [bb3_pkg::CFG_W-1:0]   cfg_data = '0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic [bb3_pkg::CH_W-1:0]    in_red = '0;
	logic [bb3_pkg::CH_W-1:0]    in_green = '0;
	logic [bb3_pkg::CH_W-1:0]    in_blue = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic [bb3_pkg::COORD_W-1:0] out_row;
	logic [bb3_pkg::COORD_W-1:0] out_col;
	logic [bb3_pkg::CH_W-1:0]    out_red;
	logic [bb3_pkg::CH_W-1:0]    out_green;
	logic [bb3_pkg::CH_W-1:0]    out_blue;
	logic                        run_last;

	// shadow of the block state
	logic [bb3_pkg::CFG_W-1:0] width_reg = 11'd1024;
	logic [bb3_pkg::CFG_W-1:0] height_reg = 11'd1024;
	bb3_pkg::pix_t             line_mem [2*bb3_pkg::MAX_WIDTH];
	bb3_pkg::pix_t             win [9];
	int                        row_pos = 0;
	int                        col_pos = 0;

	blur_px_t blurred_q [$];
	int       items_sent = 0;
	int       cycles = 0;
	bit       failed = 0;
	int       burst_left = 0;

	box_blur_three_by_three_core uut (.*);

	// clock
	initial begin
		forever #2 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// receiver stall pattern: runs of stalls, runs of flow, some long quiet spells
	int stall_left = 0;
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
		end else if (out_stall) begin
			out_stall <= 1'b0;
			stall_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 6);
		end else begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(0, 3);
		end
	end

	function automatic int eff_w();
		if (width_reg == 0) return 1;
		if (width_reg > bb3_pkg::MAX_WIDTH) return bb3_pkg::MAX_WIDTH;
		return int'(width_reg);
	endfunction

	function automatic int eff_h();
		if (height_reg == 0) return 1;
		if (height_reg > bb3_pkg::MAX_HEIGHT) return bb3_pkg::MAX_HEIGHT;
		return int'(height_reg);
	endfunction

	// mean of in-image pixels around window cell (ca,cb)
	function automatic blur_px_t blur_cell(int ca, int cb, int r, int c, int h, int w);
		blur_px_t px;
		int sr, sg, sb, cnt, ir, ic;
		sr = 0; sg = 0; sb = 0; cnt = 0;
		for (int a = ca - 1; a <= ca + 1; a++)
			for (int b = cb - 1; b <= cb + 1; b++) begin
				ir = r - 2 + a;
				ic = c - 2 + b;
				if (a < 0 || a > 2 || b < 0 || b > 2) continue;
				if (ir < 0 || ir >= h || ic < 0 || ic >= w) continue;
				sr += int'(win[a*3+b][23:16]);
				sg += int'(win[a*3+b][15:8]);
				sb += int'(win[a*3+b][7:0]);
				cnt++;
			end
		if (cnt == 0) cnt = 1;
		px.row = bb3_pkg::COORD_W'(r - 2 + ca);
		px.col = bb3_pkg::COORD_W'(c - 2 + cb);
		px.red = bb3_pkg::CH_W'((2*sr + cnt) / (2*cnt));
		px.green = bb3_pkg::CH_W'((2*sg + cnt) / (2*cnt));
		px.blue = bb3_pkg::CH_W'((2*sb + cnt) / (2*cnt));
		px.last = 1'b0;
		return px;
	endfunction

	// advance the shadow state by one pixel and queue the blurred pixels it releases
	function automatic void predict_blur(logic [7:0] r8, logic [7:0] g8, logic [7:0] b8);
		int w, h, r, c, nr, nc, n;
		int rws [2];
		int cls [2];
		bb3_pkg::pix_t pix, older, newer;
		blur_px_t px;
		w = eff_w();
		h = eff_h();
		if (col_pos >= w || row_pos >= h) begin
			row_pos = 0;
			col_pos = 0;
		end
		r = row_pos;
		c = col_pos;
		pix = {r8, g8, b8};
		older = line_mem[c];
		newer = line_mem[bb3_pkg::MAX_WIDTH + c];
		line_mem[c] = newer;
		line_mem[bb3_pkg::MAX_WIDTH + c] = pix;
		for (int k = 0; k < 3; k++) begin
			win[k*3] = win[k*3+1];
			win[k*3+1] = win[k*3+2];
		end
		win[2] = older;
		win[5] = newer;
		win[8] = pix;
		nr = 0; nc = 0; n = 0;
		if (r >= 1) rws[nr++] = 1;
		if (r == h - 1) rws[nr++] = 2;
		if (c >= 1) cls[nc++] = 1;
		if (c == w - 1) cls[nc++] = 2;
		for (int x = 0; x < nr; x++)
			for (int y = 0; y < nc; y++) begin
				px = blur_cell(rws[x], cls[y], r, c, h, w);
				n++;
				px.last = (n == nr * nc);
				blurred_q.push_back(px);
			end
		col_pos = c + 1;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos = r + 1;
			if (row_pos >= h) row_pos = 0;
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		blur_px_t exp_px;
		if (arst_n && out_valid && !out_stall) begin
			if (blurred_q.size() == 0) begin
				$error("unexpected result row %0d col %0d", out_row, out_col);
				failed = 1;
			end else begin
				exp_px = blurred_q.pop_front();
				if (out_row !== exp_px.row) begin
					$error("out_row expected %0d got %0d", exp_px.row, out_row);
					failed = 1;
				end
				if (out_col !== exp_px.col) begin
					$error("out_col expected %0d got %0d", exp_px.col, out_col);
					failed = 1;
				end
				if (out_red !== exp_px.red) begin
					$error("out_red expected %0d got %0d", exp_px.red, out_red);
					failed = 1;
				end
				if (out_green !== exp_px.green) begin
					$error("out_green expected %0d got %0d", exp_px.green, out_green);
					failed = 1;
				end
				if (out_blue !== exp_px.blue) begin
					$error("out_blue expected %0d got %0d", exp_px.blue, out_blue);
					failed = 1;
				end
				if (run_last !== exp_px.last) begin
					$error("run_last expected %0d got %0d", exp_px.last, run_last);
					failed = 1;
				end
			end
		end
	end

	// send one pixel; bursts of random length with random gaps between them
	task automatic send_pixel(logic [7:0] r8, logic [7:0] g8, logic [7:0] b8);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_red <= r8;
		in_green <= g8;
		in_blue <= b8;
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
		predict_blur(r8, g8, b8);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_random_pixel();
		send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	// wait until every blurred pixel is out and the block is quiet
	task automatic drain();
		in_valid <= 1'b0;
		while (blurred_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [bb3_pkg::CFG_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_write <= 1'b0;
		if (idx == bb3_pkg::REG_WIDTH) width_reg = val;
		else height_reg = val;
		row_pos = 0;
		col_pos = 0;
		@(negedge clk);
	endtask

	task automatic set_frame(int w, int h);
		write_reg(bb3_pkg::REG_WIDTH, bb3_pkg::CFG_W'(w));
		write_reg(bb3_pkg::REG_HEIGHT, bb3_pkg::CFG_W'(h));
	endtask

	// full 3x3 frame with extreme channel values: corner, edge and interior means
	task automatic test_extreme_frame();
		set_frame(3, 3);
		send_pixel(8'h00, 8'hFF, 8'h00);
		send_pixel(8'hFF, 8'h00, 8'hFF);
		send_pixel(8'hFF, 8'hFF, 8'hFF);
		send_pixel(8'h00, 8'h00, 8'h00);
		send_pixel(8'hFF, 8'hFF, 8'hFF);
		send_pixel(8'hAA, 8'h55, 8'h01);
		send_pixel(8'h55, 8'hAA, 8'hFE);
		send_pixel(8'hFF, 8'h00, 8'h80);
		send_pixel(8'h7F, 8'h80, 8'hFF);
		drain();
	endtask

	// degenerate shapes give neighbour counts of one, two and three
	task automatic test_thin_frames();
		set_frame(1, 1);
		send_pixel(8'hFF, 8'h00, 8'h7F);
		send_pixel(8'h01, 8'hFE, 8'h80);
		drain();
		set_frame(2, 1);
		send_pixel(8'hFF, 8'h00, 8'h01);
		send_pixel(8'h00, 8'h01, 8'hFF);
		drain();
		set_frame(1, 3);
		send_pixel(8'hFF, 8'hFF, 8'h00);
		send_pixel(8'h00, 8'h01, 8'h01);
		send_pixel(8'h01, 8'h00, 8'hFF);
		drain();
	endtask

	// register values outside the meaningful range are clamped
	task automatic test_clamped_sizes();
		set_frame(0, 0);
		send_random_pixel();
		drain();
		set_frame(2047, 1);
		repeat (4) send_random_pixel();
		drain();
		set_frame(1, 2047);
		repeat (4) send_random_pixel();
		drain();
	endtask

	// the largest legal sizes, fed only in part
	task automatic test_largest_sizes();
		set_frame(1024, 1);
		repeat (30) send_random_pixel();
		drain();
		set_frame(1, 1024);
		repeat (30) send_random_pixel();
		drain();
		set_frame(1024, 1024);
		repeat (20) send_random_pixel();
		drain();
	endtask

	// random small frames: mostly whole frames, some back to back, some cut short
	task automatic test_random_frames();
		int w, h, n;
		while (items_sent < 370) begin
			w = $urandom_range(1, 9);
			h = $urandom_range(1, 6);
			if ($urandom_range(0, 1)) set_frame(w, h);
			else if ($urandom_range(0, 1)) write_reg(bb3_pkg::REG_WIDTH, bb3_pkg::CFG_W'(w));
			else write_reg(bb3_pkg::REG_HEIGHT, bb3_pkg::CFG_W'(h));
			w = eff_w();
			h = eff_h();
			case ($urandom_range(0, 5))
				0: n = $urandom_range(1, w * h);
				1: n = 2 * w * h + $urandom_range(0, w);
				default: n = w * h;
			endcase
			repeat (n) send_random_pixel();
			drain();
		end
	endtask

	// sequence
	initial begin
		for (int i = 0; i < 9; i++) win[i] = '0;
		for (int i = 0; i < 2*bb3_pkg::MAX_WIDTH; i++) line_mem[i] = '0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_extreme_frame();
		test_thin_frames();
		test_clamped_sizes();
		test_largest_sizes();
		test_random_frames();
		if (!failed) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/bb3_pkg.sv
hw/rtl/bb3_ram.sv
hw/rtl/box_blur_three_by_three_core.sv
tb/sv/box_blur_three_by_three_core_tb.sv
